// ===== rtl/frb_pkg.sv =====
// Shared types, constants and config decode for the first bright row band finder.
// Used by frb_cfg, frb_core and first_bright_row_band_finder.
`timescale 1ns / 1ps

package frb_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W   = 8;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int DIM_W   = 13;
    localparam int RUN_W   = 13;
    localparam int CNT_W   = 13;
    localparam int FRAC_W  = 17;
    localparam int Q16_SH  = 16;
    localparam int PROD_W  = FRAC_W + DIM_W;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 17;

    localparam logic [FRAC_W-1:0] Q16_ONE = FRAC_W'(65536);

    typedef enum logic [IDX_W-1:0] {
        CFG_THRESHOLD    = 3'd0,
        CFG_RUN_LENGTH   = 3'd1,
        CFG_FRACTION     = 3'd2,
        CFG_FRAME_WIDTH  = 3'd3,
        CFG_FRAME_HEIGHT = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'b001,
        PH_CONFIRM = 3'b010,
        PH_FOUND   = 3'b100
    } phase_t;

    // Settings as the datapath sees them: clamped, decoded, product precomputed.
    typedef struct packed {
        logic [PIX_W-1:0]  threshold;
        logic [RUN_W-1:0]  need;
        logic              frac_ok;
        logic [COL_W-1:0]  width_m1;
        logic [ROW_W-1:0]  height_m1;
        logic [PROD_W-1:0] frac_prod;
    } cfg_t;

    // Per-beat status from the row/band tracker.
    typedef struct packed {
        logic             end_frame;
        logic             found;
        logic [ROW_W-1:0] anchor;
    } res_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/frb_cfg.sv =====
// Configuration register file and registered decode (clamp, fraction * width).
// Depends on frb_pkg.
`timescale 1ns / 1ps

module frb_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [frb_pkg::IDX_W-1:0]     cfg_index,
    input  logic [frb_pkg::DATA_W-1:0]    cfg_data,
    output frb_pkg::cfg_t                 cfg
);

    logic [frb_pkg::PIX_W-1:0]  threshold_reg;
    logic [frb_pkg::RUN_W-1:0]  run_length_reg;
    logic [frb_pkg::FRAC_W-1:0] fraction_reg;
    logic [frb_pkg::DIM_W-1:0]  width_reg;
    logic [frb_pkg::DIM_W-1:0]  height_reg;

    logic [frb_pkg::DIM_W-1:0]  width_cl;
    logic [frb_pkg::DIM_W-1:0]  height_cl;
    frb_pkg::cfg_t              cfg_next;
    frb_pkg::cfg_t              cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= frb_pkg::PIX_W'(128);
            run_length_reg <= frb_pkg::RUN_W'(1);
            fraction_reg   <= frb_pkg::Q16_ONE;
            width_reg      <= frb_pkg::DIM_W'(640);
            height_reg     <= frb_pkg::DIM_W'(480);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                frb_pkg::CFG_THRESHOLD:    threshold_reg  <= cfg_data[frb_pkg::PIX_W-1:0];
                frb_pkg::CFG_RUN_LENGTH:   run_length_reg <= cfg_data[frb_pkg::RUN_W-1:0];
                frb_pkg::CFG_FRACTION:     fraction_reg   <= cfg_data[frb_pkg::FRAC_W-1:0];
                frb_pkg::CFG_FRAME_WIDTH:  width_reg      <= cfg_data[frb_pkg::DIM_W-1:0];
                frb_pkg::CFG_FRAME_HEIGHT: height_reg     <= cfg_data[frb_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        width_cl  = frb_pkg::clamp_dim(width_reg, frb_pkg::DIM_W'(frb_pkg::MAX_WIDTH));
        height_cl = frb_pkg::clamp_dim(height_reg, frb_pkg::DIM_W'(frb_pkg::MAX_HEIGHT));

        cfg_next.threshold = threshold_reg;
        cfg_next.need      = (run_length_reg == '0) ? frb_pkg::RUN_W'(1) : run_length_reg;
        cfg_next.frac_ok   = (fraction_reg != '0) && (fraction_reg <= frb_pkg::Q16_ONE);
        cfg_next.width_m1  = frb_pkg::COL_W'(width_cl - frb_pkg::DIM_W'(1));
        cfg_next.height_m1 = frb_pkg::ROW_W'(height_cl - frb_pkg::DIM_W'(1));
        cfg_next.frac_prod = frb_pkg::PROD_W'(fraction_reg) * frb_pkg::PROD_W'(width_cl);
    end

    // Decode is registered. User must make writes land only while idle; unenforced.
    always_ff @(posedge aclk) begin
        cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/frb_core.sv =====
// Row and band tracker: pixel compare, row counters and search state machine.
// Depends on frb_pkg.
`timescale 1ns / 1ps

module frb_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  logic [frb_pkg::PIX_W-1:0] pixel,
    input  frb_pkg::cfg_t             cfg,
    output frb_pkg::res_t             res
);

    logic [frb_pkg::COL_W-1:0]  col_reg;
    logic [frb_pkg::ROW_W-1:0]  row_reg;
    logic                       all_reg;
    logic [frb_pkg::CNT_W-1:0]  cnt_reg;
    frb_pkg::phase_t            phase_reg;
    logic [frb_pkg::RUN_W-1:0]  conf_reg;
    logic [frb_pkg::ROW_W-1:0]  band_reg;

    frb_pkg::phase_t            phase_next;
    logic [frb_pkg::RUN_W-1:0]  conf_next;
    logic [frb_pkg::ROW_W-1:0]  band_next;

    logic                       bright;
    logic                       all_now;
    logic [frb_pkg::CNT_W-1:0]  cnt_now;
    logic                       end_row;
    logic                       end_frame;
    logic                       frac_pass;
    logic [frb_pkg::RUN_W:0]    conf_sum;
    logic                       conf_done;

    always_comb begin
        bright    = (pixel >= cfg.threshold);
        all_now   = all_reg & bright;
        cnt_now   = (bright && (cnt_reg != '1)) ? cnt_reg + frb_pkg::CNT_W'(1) : cnt_reg;
        end_row   = (col_reg >= cfg.width_m1);
        end_frame = end_row && (row_reg >= cfg.height_m1);
        // count * 65536 >= fraction * width
        frac_pass = (frb_pkg::PROD_W'({cnt_now, frb_pkg::Q16_SH'(0)}) >= cfg.frac_prod);
        conf_sum  = {1'b0, conf_reg} + (frb_pkg::RUN_W + 1)'(1);
        conf_done = (conf_sum >= {1'b0, cfg.need});
    end

    // Band decision at the close of a row.
    always_comb begin
        phase_next = phase_reg;
        conf_next  = conf_reg;
        band_next  = band_reg;
        unique case (phase_reg)
            frb_pkg::PH_SEARCH: begin
                if (all_now && cfg.frac_ok) begin
                    band_next  = row_reg;
                    conf_next  = frb_pkg::RUN_W'(1);
                    phase_next = (cfg.need == frb_pkg::RUN_W'(1)) ? frb_pkg::PH_FOUND
                                                                   : frb_pkg::PH_CONFIRM;
                end
            end
            frb_pkg::PH_CONFIRM: begin
                if (frac_pass) begin
                    conf_next = conf_sum[frb_pkg::RUN_W-1:0];
                    if (conf_done) begin
                        phase_next = frb_pkg::PH_FOUND;
                    end
                end else begin
                    phase_next = frb_pkg::PH_SEARCH;
                    conf_next  = '0;
                    band_next  = '0;
                end
            end
            frb_pkg::PH_FOUND: ;
            default: begin
                phase_next = frb_pkg::PH_SEARCH;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            all_reg   <= 1'b1;
            cnt_reg   <= '0;
            phase_reg <= frb_pkg::PH_SEARCH;
            conf_reg  <= '0;
            band_reg  <= '0;
        end else if (step) begin
            if (end_frame) begin
                // Result goes out this beat; clear for the next frame.
                col_reg   <= '0;
                row_reg   <= '0;
                all_reg   <= 1'b1;
                cnt_reg   <= '0;
                phase_reg <= frb_pkg::PH_SEARCH;
                conf_reg  <= '0;
                band_reg  <= '0;
            end else if (end_row) begin
                col_reg   <= '0;
                row_reg   <= row_reg + frb_pkg::ROW_W'(1);
                all_reg   <= 1'b1;
                cnt_reg   <= '0;
                phase_reg <= phase_next;
                conf_reg  <= conf_next;
                band_reg  <= band_next;
            end else begin
                col_reg <= col_reg + frb_pkg::COL_W'(1);
                all_reg <= all_now;
                cnt_reg <= cnt_now;
            end
        end
    end

    always_comb begin
        res.end_frame = end_frame;
        res.found     = (phase_next == frb_pkg::PH_FOUND);
        res.anchor    = res.found ? band_next : '0;
    end

endmodule

// ===== rtl/first_bright_row_band_finder.sv =====
// First bright row band finder: one pixel per clock, one result per frame.
// The frame's last pixel beat passes the input register; its result is held in the output register.
// Throughput: one pixel beat per cycle; the input register only waits when a
// frame result is blocked in the output register by m_ready low.
// Reset: aresetn synchronous, active low; config registers return to defaults, frame state clears.
// Config decode (clamp, fraction * width product) is registered behind the config registers.
`timescale 1ns / 1ps

module first_bright_row_band_finder (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [frb_pkg::PIX_W-1:0]  s_pixel,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_found,
    output logic [frb_pkg::ROW_W-1:0]  m_anchor_row,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [frb_pkg::IDX_W-1:0]  cfg_index,
    input  logic [frb_pkg::DATA_W-1:0] cfg_data
);

    frb_pkg::cfg_t              cfg;
    frb_pkg::res_t              res;

    logic                       in_valid_reg;
    logic [frb_pkg::PIX_W-1:0]  pix_reg;
    logic                       out_valid_reg;
    logic                       found_reg;
    logic [frb_pkg::ROW_W-1:0]  anchor_reg;
    logic                       step;

    assign cfg_ready = 1'b1;

    frb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    frb_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .pixel   (pix_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Advance unless this beat ends a frame and the result slot is still full.
    assign step    = in_valid_reg && (!res.end_frame || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pix_reg <= s_pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && res.end_frame) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res.end_frame) begin
            found_reg  <= res.found;
            anchor_reg <= res.anchor;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_found      = found_reg;
    assign m_anchor_row = anchor_reg;

`ifndef SYNTH
    // A held input beat keeps its pixel.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(pix_reg)))
        else $error("input beat dropped or changed while stalled");

    // Input side only backs up behind a blocked frame result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && res.end_frame && out_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    // A not-found result carries row zero.
    a_anchor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_anchor_row == '0))
        else $error("anchor row nonzero on not-found result");

    // A pending result is not overwritten.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !(step && res.end_frame))
        else $error("frame result overwrote pending result");
`endif

endmodule

// ===== sim/tb_first_bright_row_band_finder.sv =====
// Self-checking testbench for first_bright_row_band_finder: pixel frames in, band result out.
// Depends on rtl/frb_pkg.sv and the block's RTL; predicts each frame's result on its own.
`timescale 1ns / 1ps

module tb_first_bright_row_band_finder;

    localparam int RAND_PIXELS = 1150;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 4;
    localparam int DRAIN_LIMIT = 50000;

    typedef struct packed {
        logic                      found;
        logic [frb_pkg::ROW_W-1:0] anchor;
    } band_t;

    logic                         aclk;
    logic                         aresetn   = 1'b0;
    logic                         s_valid   = 1'b0;
    logic                         s_ready;
    logic [frb_pkg::PIX_W-1:0]    s_pixel   = '0;
    logic                         m_valid;
    logic                         m_ready   = 1'b0;
    logic                         m_found;
    logic [frb_pkg::ROW_W-1:0]    m_anchor_row;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [frb_pkg::IDX_W-1:0]    cfg_index = '0;
    logic [frb_pkg::DATA_W-1:0]   cfg_data  = '0;

    // register copies, reset values
    logic [frb_pkg::PIX_W-1:0]    cfg_thresh = 8'd128;
    logic [frb_pkg::RUN_W-1:0]    cfg_run    = 13'd1;
    logic [frb_pkg::FRAC_W-1:0]   cfg_frac   = 17'd65536;
    logic [frb_pkg::DIM_W-1:0]    cfg_width  = 13'd640;
    logic [frb_pkg::DIM_W-1:0]    cfg_height = 13'd480;

    // frame tracking for the predictor
    int                           col_pos    = 0;
    int                           row_pos    = 0;
    bit                           all_lit    = 1'b1;
    int                           lit_count  = 0;
    frb_pkg::phase_t              band_phase = frb_pkg::PH_SEARCH;
    int                           rows_ok    = 0;
    logic [frb_pkg::ROW_W-1:0]    band_first = '0;
    int                           need_rows;
    int                           eff_w;
    int                           eff_h;
    bit                           row_done;
    bit                           frame_done;
    band_t                        next_band;

    logic [frb_pkg::PIX_W-1:0]    pixel_q [$];
    band_t                        band_q [$];
    band_t                        head_band;
    int                           pixels_pushed  = 0;
    int                           pixels_taken   = 0;
    int                           fail_count     = 0;
    int                           send_idle_pct  = 0;
    int                           recv_stall_pct = 0;
    logic                         hold_arm       = 1'b0;
    int                           hold_left      = 0;

    first_bright_row_band_finder u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_anchor_row (m_anchor_row),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int bound_dim(input int v, input int maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic logic [frb_pkg::PIX_W-1:0] make_pixel(input bit want_bright);
        if (want_bright || cfg_thresh == 0) begin
            return frb_pkg::PIX_W'($urandom_range(255, cfg_thresh));
        end
        return frb_pkg::PIX_W'($urandom_range(cfg_thresh - 1, 0));
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    // Sender: hold the beat until accepted, then take the next pixel or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_pixel <= pixel_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_arm) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Band predictor: advance on every accepted pixel beat.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            pixels_taken++;
            eff_w = bound_dim(cfg_width, frb_pkg::MAX_WIDTH);
            eff_h = bound_dim(cfg_height, frb_pkg::MAX_HEIGHT);
            if (s_pixel >= cfg_thresh) begin
                if (lit_count < 8191) lit_count++;
            end else begin
                all_lit = 1'b0;
            end
            row_done   = (col_pos + 1 >= eff_w);
            frame_done = row_done && (row_pos + 1 >= eff_h);
            if (row_done) begin
                need_rows = (cfg_run == 0) ? 1 : int'(cfg_run);
                if (band_phase == frb_pkg::PH_SEARCH) begin
                    if (all_lit && cfg_frac != 0 && cfg_frac <= 65536) begin
                        band_first = row_pos[frb_pkg::ROW_W-1:0];
                        rows_ok    = 1;
                        band_phase = (need_rows <= 1) ? frb_pkg::PH_FOUND
                                                      : frb_pkg::PH_CONFIRM;
                    end
                end else if (band_phase == frb_pkg::PH_CONFIRM) begin
                    // exact rational compare: count / width >= frac / 65536
                    if (longint'(lit_count) * 65536 >= longint'(cfg_frac) * eff_w) begin
                        rows_ok++;
                        if (rows_ok >= need_rows) band_phase = frb_pkg::PH_FOUND;
                    end else begin
                        band_phase = frb_pkg::PH_SEARCH;
                        rows_ok    = 0;
                        band_first = '0;
                    end
                end
                all_lit   = 1'b1;
                lit_count = 0;
                col_pos   = 0;
            end else begin
                col_pos++;
            end
            if (frame_done) begin
                next_band.found  = (band_phase == frb_pkg::PH_FOUND);
                next_band.anchor = (band_phase == frb_pkg::PH_FOUND) ? band_first : '0;
                band_q.push_back(next_band);
                row_pos    = 0;
                band_phase = frb_pkg::PH_SEARCH;
                rows_ok    = 0;
                band_first = '0;
            end else if (row_done) begin
                row_pos++;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (band_q.size() == 0) begin
                note_failure($sformatf("unexpected result beat: found=%0d anchor=%0d",
                                       m_found, m_anchor_row));
            end else begin
                head_band = band_q.pop_front();
                if (m_found !== head_band.found || m_anchor_row !== head_band.anchor) begin
                    note_failure($sformatf(
                        "band mismatch: expected found=%0d anchor=%0d, got found=%0d anchor=%0d",
                        head_band.found, head_band.anchor, m_found, m_anchor_row));
                end
            end
        end
    end

    task automatic push_pixel(input logic [frb_pkg::PIX_W-1:0] p);
        pixel_q.push_back(p);
        pixels_pushed++;
    endtask

    // Wait until every pixel is taken and every result is back, then let the pipe settle.
    task automatic drain();
        int guard;
        guard = 0;
        while ((pixels_taken != pixels_pushed || band_q.size() != 0) && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input frb_pkg::cfg_idx_t idx, input int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= frb_pkg::DATA_W'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            frb_pkg::CFG_THRESHOLD:    cfg_thresh = frb_pkg::PIX_W'(value);
            frb_pkg::CFG_RUN_LENGTH:   cfg_run    = frb_pkg::RUN_W'(value);
            frb_pkg::CFG_FRACTION:     cfg_frac   = frb_pkg::FRAC_W'(value);
            frb_pkg::CFG_FRAME_WIDTH:  cfg_width  = frb_pkg::DIM_W'(value);
            frb_pkg::CFG_FRAME_HEIGHT: cfg_height = frb_pkg::DIM_W'(value);
            default: ;
        endcase
    endtask

    task automatic load_setup(input int thr, input int run, input int frac,
                              input int w, input int h);
        drain();
        write_reg(frb_pkg::CFG_THRESHOLD, thr);
        write_reg(frb_pkg::CFG_RUN_LENGTH, run);
        write_reg(frb_pkg::CFG_FRACTION, frac);
        write_reg(frb_pkg::CFG_FRAME_WIDTH, w);
        write_reg(frb_pkg::CFG_FRAME_HEIGHT, h);
    endtask

    // Rows are mostly fully bright or mostly bright so that bands actually form.
    task automatic queue_frames(input int n);
        int ew;
        int eh;
        int kind;
        int lit_pct;
        ew = bound_dim(cfg_width, frb_pkg::MAX_WIDTH);
        eh = bound_dim(cfg_height, frb_pkg::MAX_HEIGHT);
        repeat (n) begin
            for (int r = 0; r < eh; r++) begin
                kind    = $urandom_range(9);
                lit_pct = (kind < 4) ? 100 : ((kind < 8) ? $urandom_range(100, 50) : -1);
                for (int c = 0; c < ew; c++) begin
                    if (lit_pct < 0) push_pixel(frb_pkg::PIX_W'($urandom));
                    else push_pixel(make_pixel($urandom_range(99) < lit_pct));
                end
            end
        end
    endtask

    task automatic pick_random_setup();
        int w;
        int h;
        int ew;
        int eh;
        int thr;
        int run;
        int frac;
        int k;
        w  = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
        h  = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
        ew = bound_dim(w, frb_pkg::MAX_WIDTH);
        eh = bound_dim(h, frb_pkg::MAX_HEIGHT);
        case ($urandom_range(5))
            0:       thr = 0;
            1:       thr = 255;
            default: thr = $urandom_range(255);
        endcase
        case ($urandom_range(7))
            0:       run = 0;
            1:       run = 1;
            2:       run = eh;
            3:       run = eh + 1;
            4:       run = 8191;
            default: run = $urandom_range(3, 2);
        endcase
        k = $urandom_range(ew, 0);
        case ($urandom_range(7))
            0:       frac = 0;
            1:       frac = 65536;
            2:       frac = (k * 65536) / ew;
            3:       frac = (k * 65536) / ew + 1;
            4:       frac = (k == 0) ? 1 : (k * 65536) / ew - 1;
            5:       frac = $urandom_range(131071, 65537);
            6:       frac = 1;
            default: frac = $urandom_range(65536, 1);
        endcase
        load_setup(thr, run, frac, w, h);
    endtask

    initial begin
        logic [frb_pkg::PIX_W-1:0] dir_pix [$];
        int                        phase_no;
        int                        rand_base;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Threshold edge 127/128, failed follow-up row, band cut off by frame end.
        load_setup(128, 2, 49152, 4, 3);
        dir_pix = '{128, 255, 200, 130, 255, 127, 200, 0, 255, 255, 255, 255};
        foreach (dir_pix[i]) push_pixel(dir_pix[i]);
        // Zero run length acts like one.
        load_setup(128, 0, 65536, 2, 2);
        dir_pix = '{0, 255, 255, 128};
        foreach (dir_pix[i]) push_pixel(dir_pix[i]);
        // Fraction of zero and above one: never found.
        load_setup(128, 1, 0, 2, 1);
        push_pixel(8'd255);
        push_pixel(8'd255);
        load_setup(128, 1, 131071, 2, 1);
        push_pixel(8'd255);
        push_pixel(8'd255);

        phase_no  = 0;
        rand_base = pixels_pushed;
        while (pixels_pushed - rand_base < RAND_PIXELS) begin
            pick_random_setup();
            case (phase_no % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            queue_frames($urandom_range(6, 1));
            phase_no++;
        end

        // Long receiver hold-off with the sender running flat out: fill the block.
        load_setup(128, 1, 65536, 2, 2);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        hold_arm <= 1'b1;
        @(posedge aclk);
        hold_arm <= 1'b0;
        queue_frames(15);

        // Zero width clamps to one column; band on the last row.
        load_setup(200, 1, 65536, 0, 3);
        push_pixel(8'd10);
        push_pixel(8'd199);
        push_pixel(8'd255);
        // Zero height clamps to one row.
        load_setup(100, 0, 65536, 4, 0);
        repeat (4) push_pixel(make_pixel(1'b1));

        drain();
        repeat (10) @(posedge aclk);
        if (band_q.size() != 0 || pixels_taken != pixels_pushed) begin
            note_failure($sformatf("%0d results still outstanding, %0d pixels not taken",
                                   band_q.size(), pixels_pushed - pixels_taken));
        end
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
